FILE: rtl/dltq_pkg.sv
package dltq_pkg;

  localparam logic [2:0] CMD_TICK  = 3'd0;
  localparam logic [2:0] CMD_START = 3'd1;
  localparam logic [2:0] CMD_STOP  = 3'd2;
  localparam logic [2:0] CMD_MODE  = 3'd3;
  localparam logic [2:0] CMD_POLL  = 3'd4;

  localparam logic [1:0] KIND_DONE   = 2'd0;
  localparam logic [1:0] KIND_FIRED  = 2'd1;
  localparam logic [1:0] KIND_EMPTY  = 2'd2;
  localparam logic [1:0] KIND_REJECT = 2'd3;

  localparam logic [1:0] PLACE_IDLE    = 2'd0;
  localparam logic [1:0] PLACE_RUNNING = 2'd1;
  localparam logic [1:0] PLACE_READY   = 2'd2;

  localparam int MAX_RESULTS = 16;
  localparam int POLL_BITS   = 5;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_LATCH,
    OP_TICK_DEC,
    OP_POP_HEAD,
    OP_WALK_INC,
    OP_LIST_REMOVE,
    OP_FIFO_REMOVE,
    OP_SET_SLOT,
    OP_SET_REP,
    OP_INS_STEP,
    OP_POLL_POP,
    OP_LOAD_PERIOD,
    OP_EMIT
  } dp_op_t;

  typedef enum logic [1:0] {
    ACT_ZERO,
    ACT_ONE,
    ACT_LOOKUP
  } act_sel_t;

  typedef struct packed {
    dp_op_t     op;
    logic [1:0] kind;
    logic       use_cur;
    act_sel_t   act;
    logic       last;
  } dp_cmd_t;

  typedef struct packed {
    logic [2:0] cmd;
    logic       ok_id;
    logic       period_zero;
    logic [1:0] place;
    logic       list_empty;
    logic       fifo_empty;
    logic       head_zero;
    logic       list_hit;
    logic       fifo_hit;
    logic       ins_place;
    logic       rep_cur;
    logic       poll_last;
  } dp_status_t;

endpackage

FILE: rtl/dltq_ram.sv
module dltq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/dltq_dp.sv
module dltq_dp #(
  parameter int NUM_TIMERS  = 16,
  parameter int PERIOD_BITS = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [2:0]           in_command,
  input  logic [3:0]           in_timer_id,
  input  logic [31:0]          in_period,
  input  logic                 in_repeat_req,
  input  dltq_pkg::dp_cmd_t    cmd_i,
  output dltq_pkg::dp_status_t status_o,
  output logic                 out_valid,
  output logic [1:0]           out_kind,
  output logic [3:0]           out_fired_or_addressed_id,
  output logic                 out_active,
  output logic                 out_last
);

  localparam int IW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam int CW = $clog2(NUM_TIMERS + 1);
  localparam int PB = PERIOD_BITS;
  localparam int NW = dltq_pkg::POLL_BITS;

  logic [IW-1:0] ord_r  [NUM_TIMERS];
  logic [IW-1:0] ord_nxt [NUM_TIMERS];
  logic [PB-1:0] dlt_r  [NUM_TIMERS];
  logic [PB-1:0] dlt_nxt [NUM_TIMERS];
  logic [IW-1:0] fifo_r [NUM_TIMERS];
  logic [IW-1:0] fifo_nxt [NUM_TIMERS];
  logic [1:0]    place_r [NUM_TIMERS];
  logic [1:0]    place_nxt [NUM_TIMERS];
  logic          rep_r [NUM_TIMERS];
  logic          rep_nxt [NUM_TIMERS];

  logic [CW-1:0] rcnt_r, rcnt_nxt;
  logic [CW-1:0] fcnt_r, fcnt_nxt;
  logic [IW-1:0] walk_r, walk_nxt;
  logic [PB:0]   total_r, total_nxt;
  logic [IW-1:0] cur_id_r, cur_id_nxt;
  logic [PB-1:0] cur_p_r, cur_p_nxt;
  logic [2:0]    in_cmd_r, in_cmd_nxt;
  logic [3:0]    in_id_r, in_id_nxt;
  logic          in_rep_r, in_rep_nxt;
  logic [NW-1:0] npoll_r, npoll_nxt;

  logic          out_valid_r, out_valid_nxt;
  logic [1:0]    out_kind_r, out_kind_nxt;
  logic [3:0]    out_id_r, out_id_nxt;
  logic          out_active_r, out_active_nxt;
  logic          out_last_r, out_last_nxt;

  logic [PB-1:0] ram_rdata;
  logic          ram_we;

  logic [IW-1:0] in_id_w;
  logic          id_ok;
  logic [IW-1:0] walk_p1;
  logic [PB-1:0] dlt_w, dlt_w1, fold;
  logic          fold_ok;
  logic          at_end;
  logic [PB:0]   ntotal;
  logic [PB:0]   p_ext;
  logic          ins_place;
  logic [PB-1:0] ins_d;
  logic [IW-1:0] head_id, fifo_head;
  logic          act_in, act_cur;

  assign in_id_w  = IW'(in_id_r);
  assign id_ok    = (32'(in_id_r) < NUM_TIMERS);
  assign walk_p1  = walk_r + 1'b1;
  assign dlt_w    = dlt_r[walk_r];
  assign dlt_w1   = (32'(walk_r) < NUM_TIMERS - 1) ? dlt_r[walk_p1] : '0;
  assign fold     = dlt_w + dlt_w1;
  assign fold_ok  = ((CW + 1)'(walk_r) + 1'b1) < (CW + 1)'(rcnt_r);
  assign at_end   = ((CW + 1)'(walk_r) == (CW + 1)'(rcnt_r));
  assign ntotal   = total_r + (PB + 1)'(dlt_w);
  assign p_ext    = (PB + 1)'(cur_p_r);
  assign ins_place = at_end || (ntotal > p_ext);
  assign ins_d    = PB'(p_ext - total_r);
  assign head_id  = ord_r[0];
  assign fifo_head = fifo_r[0];
  assign act_in   = id_ok && (place_r[in_id_w] == dltq_pkg::PLACE_RUNNING);
  assign act_cur  = (place_r[cur_id_r] == dltq_pkg::PLACE_RUNNING);
  assign ram_we   = (cmd_i.op == dltq_pkg::OP_SET_SLOT);

  dltq_ram #(
    .WIDTH (PB),
    .DEPTH (NUM_TIMERS)
  ) u_period (
    .clk   (clk),
    .we    (ram_we),
    .waddr (cur_id_r),
    .wdata (cur_p_r),
    .raddr (cur_id_r),
    .rdata (ram_rdata)
  );

  always_comb begin
    status_o.cmd         = in_cmd_r;
    status_o.ok_id       = id_ok;
    status_o.period_zero = (cur_p_r == '0);
    status_o.place       = place_r[cur_id_r];
    status_o.list_empty  = (rcnt_r == '0);
    status_o.fifo_empty  = (fcnt_r == '0);
    status_o.head_zero   = (dlt_r[0] == '0);
    status_o.list_hit    = (ord_r[walk_r] == cur_id_r);
    status_o.fifo_hit    = (fifo_r[walk_r] == cur_id_r);
    status_o.ins_place   = ins_place;
    status_o.rep_cur     = rep_r[cur_id_r];
    status_o.poll_last   = (fcnt_r == '0) || (npoll_r == NW'(dltq_pkg::MAX_RESULTS));
  end

  always_comb begin
    ord_nxt   = ord_r;
    dlt_nxt   = dlt_r;
    fifo_nxt  = fifo_r;
    place_nxt = place_r;
    rep_nxt   = rep_r;
    rcnt_nxt  = rcnt_r;
    fcnt_nxt  = fcnt_r;
    walk_nxt  = walk_r;
    total_nxt = total_r;
    cur_id_nxt = cur_id_r;
    cur_p_nxt = cur_p_r;
    in_cmd_nxt = in_cmd_r;
    in_id_nxt = in_id_r;
    in_rep_nxt = in_rep_r;
    npoll_nxt = npoll_r;
    out_valid_nxt  = 1'b0;
    out_kind_nxt   = out_kind_r;
    out_id_nxt     = out_id_r;
    out_active_nxt = out_active_r;
    out_last_nxt   = out_last_r;

    case (cmd_i.op)
      dltq_pkg::OP_LATCH: begin
        in_cmd_nxt = in_command;
        in_id_nxt  = in_timer_id;
        in_rep_nxt = in_repeat_req;
        cur_id_nxt = IW'(in_timer_id);
        cur_p_nxt  = in_period[PB-1:0];
        walk_nxt   = '0;
        npoll_nxt  = '0;
      end
      dltq_pkg::OP_TICK_DEC: begin
        dlt_nxt[0] = dlt_r[0] - 1'b1;
      end
      dltq_pkg::OP_POP_HEAD: begin
        for (int i = 0; i < NUM_TIMERS - 1; i++) begin
          ord_nxt[i] = ord_r[i+1];
          dlt_nxt[i] = dlt_r[i+1];
        end
        rcnt_nxt = rcnt_r - 1'b1;
        if (32'(fcnt_r) < NUM_TIMERS) begin
          fifo_nxt[fcnt_r[IW-1:0]] = head_id;
          fcnt_nxt = fcnt_r + 1'b1;
          place_nxt[head_id] = dltq_pkg::PLACE_READY;
        end else begin
          place_nxt[head_id] = dltq_pkg::PLACE_IDLE;
        end
      end
      dltq_pkg::OP_WALK_INC: begin
        walk_nxt = walk_p1;
      end
      dltq_pkg::OP_LIST_REMOVE: begin
        // The removed entry's delta folds into the entry that follows it.
        for (int i = 0; i < NUM_TIMERS - 1; i++) begin
          if (IW'(i) >= walk_r) begin
            ord_nxt[i] = ord_r[i+1];
            dlt_nxt[i] = (IW'(i) == walk_r && fold_ok) ? fold : dlt_r[i+1];
          end
        end
        rcnt_nxt = rcnt_r - 1'b1;
        place_nxt[cur_id_r] = dltq_pkg::PLACE_IDLE;
      end
      dltq_pkg::OP_FIFO_REMOVE: begin
        for (int i = 0; i < NUM_TIMERS - 1; i++) begin
          if (IW'(i) >= walk_r) begin
            fifo_nxt[i] = fifo_r[i+1];
          end
        end
        fcnt_nxt = fcnt_r - 1'b1;
        place_nxt[cur_id_r] = dltq_pkg::PLACE_IDLE;
      end
      dltq_pkg::OP_SET_SLOT: begin
        rep_nxt[cur_id_r] = in_rep_r;
        total_nxt = '0;
        walk_nxt  = '0;
      end
      dltq_pkg::OP_SET_REP: begin
        rep_nxt[cur_id_r] = in_rep_r;
      end
      dltq_pkg::OP_INS_STEP: begin
        if (ins_place) begin
          for (int i = 1; i < NUM_TIMERS; i++) begin
            if (IW'(i) > walk_r) begin
              ord_nxt[i] = ord_r[i-1];
              dlt_nxt[i] = dlt_r[i-1];
            end
          end
          ord_nxt[walk_r] = cur_id_r;
          dlt_nxt[walk_r] = ins_d;
          if (!at_end) begin
            dlt_nxt[walk_p1] = dlt_w - ins_d;
          end
          rcnt_nxt = rcnt_r + 1'b1;
          place_nxt[cur_id_r] = dltq_pkg::PLACE_RUNNING;
        end else begin
          total_nxt = ntotal;
          walk_nxt  = walk_p1;
        end
      end
      dltq_pkg::OP_POLL_POP: begin
        for (int i = 0; i < NUM_TIMERS - 1; i++) begin
          fifo_nxt[i] = fifo_r[i+1];
        end
        fcnt_nxt = fcnt_r - 1'b1;
        place_nxt[fifo_head] = dltq_pkg::PLACE_IDLE;
        cur_id_nxt = fifo_head;
        npoll_nxt = npoll_r + 1'b1;
      end
      dltq_pkg::OP_LOAD_PERIOD: begin
        cur_p_nxt = ram_rdata;
        total_nxt = '0;
        walk_nxt  = '0;
      end
      dltq_pkg::OP_EMIT: begin
        out_valid_nxt = 1'b1;
        out_kind_nxt  = cmd_i.kind;
        out_id_nxt    = cmd_i.use_cur ? 4'(cur_id_r) : in_id_r;
        out_last_nxt  = cmd_i.last;
        case (cmd_i.act)
          dltq_pkg::ACT_ZERO:   out_active_nxt = 1'b0;
          dltq_pkg::ACT_ONE:    out_active_nxt = 1'b1;
          dltq_pkg::ACT_LOOKUP: out_active_nxt = cmd_i.use_cur ? act_cur : act_in;
          default:              out_active_nxt = 1'b0;
        endcase
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_TIMERS; i++) begin
        place_r[i] <= dltq_pkg::PLACE_IDLE;
        rep_r[i]   <= 1'b0;
      end
      rcnt_r      <= '0;
      fcnt_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      place_r     <= place_nxt;
      rep_r       <= rep_nxt;
      rcnt_r      <= rcnt_nxt;
      fcnt_r      <= fcnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ord_r        <= ord_nxt;
    dlt_r        <= dlt_nxt;
    fifo_r       <= fifo_nxt;
    walk_r       <= walk_nxt;
    total_r      <= total_nxt;
    cur_id_r     <= cur_id_nxt;
    cur_p_r      <= cur_p_nxt;
    in_cmd_r     <= in_cmd_nxt;
    in_id_r      <= in_id_nxt;
    in_rep_r     <= in_rep_nxt;
    npoll_r      <= npoll_nxt;
    out_kind_r   <= out_kind_nxt;
    out_id_r     <= out_id_nxt;
    out_active_r <= out_active_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_valid                 = out_valid_r;
  assign out_kind                  = out_kind_r;
  assign out_fired_or_addressed_id = out_id_r;
  assign out_active                = out_active_r;
  assign out_last                  = out_last_r;

`ifndef SYNTHESIS
  a_slots_conserved: assert property (@(posedge clk) disable iff (!rst_n)
    ((CW + 1)'(rcnt_r) + (CW + 1)'(fcnt_r)) <= (CW + 1)'(NUM_TIMERS))
    else $error("running and ready entries exceed the slot count");

  a_emit_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd_i.op == dltq_pkg::OP_EMIT) |=> out_valid_r)
    else $error("emit command did not raise the strobe");

  a_no_stray_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd_i.op != dltq_pkg::OP_EMIT) |=> !out_valid_r)
    else $error("strobe without an emit command");

  a_tick_head_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd_i.op == dltq_pkg::OP_TICK_DEC) |-> (rcnt_r != '0 && dlt_r[0] != '0))
    else $error("tick on an empty list or a zero head");
`endif

endmodule

FILE: rtl/dltq_ctrl.sv
module dltq_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  dltq_pkg::dp_status_t status_i,
  output dltq_pkg::dp_cmd_t    cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_EXPIRE,
    S_FIND_L,
    S_REM_L,
    S_FIND_F,
    S_REM_F,
    S_SET,
    S_INS,
    S_POLL_POP,
    S_CHK_REP,
    S_LOAD_P,
    S_EMIT
  } state_t;

  state_t             state_r, state_nxt;
  logic [1:0]         kind_r, kind_nxt;
  logic               use_cur_r, use_cur_nxt;
  dltq_pkg::act_sel_t act_r, act_nxt;
  logic               last_r, last_nxt;
  dltq_pkg::dp_op_t   op;

  assign busy = (state_r != S_IDLE);

  always_comb begin
    state_nxt   = state_r;
    kind_nxt    = kind_r;
    use_cur_nxt = use_cur_r;
    act_nxt     = act_r;
    last_nxt    = last_r;
    op          = dltq_pkg::OP_NOP;

    case (state_r)
      S_IDLE: begin
        if (start) begin
          op        = dltq_pkg::OP_LATCH;
          state_nxt = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        state_nxt   = S_EMIT;
        use_cur_nxt = 1'b0;
        last_nxt    = 1'b1;
        kind_nxt    = dltq_pkg::KIND_REJECT;
        act_nxt     = dltq_pkg::ACT_LOOKUP;
        case (status_i.cmd)
          dltq_pkg::CMD_TICK: begin
            kind_nxt = dltq_pkg::KIND_DONE;
            if (!status_i.list_empty) begin
              op        = dltq_pkg::OP_TICK_DEC;
              state_nxt = S_EXPIRE;
            end
          end
          dltq_pkg::CMD_START, dltq_pkg::CMD_STOP: begin
            if (status_i.cmd == dltq_pkg::CMD_STOP) begin
              act_nxt = dltq_pkg::ACT_ZERO;
            end
            if (status_i.ok_id &&
                (status_i.cmd == dltq_pkg::CMD_STOP || !status_i.period_zero)) begin
              if (status_i.place == dltq_pkg::PLACE_RUNNING) begin
                state_nxt = S_FIND_L;
              end else if (status_i.place == dltq_pkg::PLACE_READY) begin
                state_nxt = S_FIND_F;
              end else if (status_i.cmd == dltq_pkg::CMD_START) begin
                state_nxt = S_SET;
              end else begin
                kind_nxt = dltq_pkg::KIND_DONE;
              end
            end
          end
          dltq_pkg::CMD_MODE: begin
            if (status_i.ok_id) begin
              op       = dltq_pkg::OP_SET_REP;
              kind_nxt = dltq_pkg::KIND_DONE;
            end else begin
              act_nxt = dltq_pkg::ACT_ZERO;
            end
          end
          dltq_pkg::CMD_POLL: begin
            if (status_i.fifo_empty) begin
              kind_nxt = dltq_pkg::KIND_EMPTY;
            end else begin
              state_nxt = S_POLL_POP;
            end
          end
          default: begin
          end
        endcase
      end
      S_EXPIRE: begin
        // Zeroed heads pop one a cycle: to the ready queue, or idle if it is full.
        if (!status_i.list_empty && status_i.head_zero) begin
          op = dltq_pkg::OP_POP_HEAD;
        end else begin
          state_nxt = S_EMIT;
        end
      end
      S_FIND_L: begin
        if (status_i.list_hit) begin
          state_nxt = S_REM_L;
        end else begin
          op = dltq_pkg::OP_WALK_INC;
        end
      end
      S_FIND_F: begin
        if (status_i.fifo_hit) begin
          state_nxt = S_REM_F;
        end else begin
          op = dltq_pkg::OP_WALK_INC;
        end
      end
      S_REM_L, S_REM_F: begin
        op = (state_r == S_REM_L) ? dltq_pkg::OP_LIST_REMOVE : dltq_pkg::OP_FIFO_REMOVE;
        if (status_i.cmd == dltq_pkg::CMD_START) begin
          state_nxt = S_SET;
        end else begin
          kind_nxt  = dltq_pkg::KIND_DONE;
          state_nxt = S_EMIT;
        end
      end
      S_SET: begin
        op        = dltq_pkg::OP_SET_SLOT;
        state_nxt = S_INS;
      end
      S_INS: begin
        op = dltq_pkg::OP_INS_STEP;
        if (status_i.ins_place) begin
          state_nxt = S_EMIT;
          if (status_i.cmd == dltq_pkg::CMD_START) begin
            kind_nxt = dltq_pkg::KIND_DONE;
            act_nxt  = dltq_pkg::ACT_ONE;
          end else begin
            kind_nxt    = dltq_pkg::KIND_FIRED;
            use_cur_nxt = 1'b1;
            act_nxt     = dltq_pkg::ACT_LOOKUP;
            last_nxt    = status_i.poll_last;
          end
        end
      end
      S_POLL_POP: begin
        op        = dltq_pkg::OP_POLL_POP;
        state_nxt = S_CHK_REP;
      end
      S_CHK_REP: begin
        if (status_i.rep_cur) begin
          state_nxt = S_LOAD_P;
        end else begin
          kind_nxt    = dltq_pkg::KIND_FIRED;
          use_cur_nxt = 1'b1;
          act_nxt     = dltq_pkg::ACT_LOOKUP;
          last_nxt    = status_i.poll_last;
          state_nxt   = S_EMIT;
        end
      end
      S_LOAD_P: begin
        op        = dltq_pkg::OP_LOAD_PERIOD;
        state_nxt = S_INS;
      end
      S_EMIT: begin
        op        = dltq_pkg::OP_EMIT;
        state_nxt = last_r ? S_IDLE : S_POLL_POP;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      kind_r    <= dltq_pkg::KIND_DONE;
      use_cur_r <= 1'b0;
      act_r     <= dltq_pkg::ACT_ZERO;
      last_r    <= 1'b1;
    end else begin
      state_r   <= state_nxt;
      kind_r    <= kind_nxt;
      use_cur_r <= use_cur_nxt;
      act_r     <= act_nxt;
      last_r    <= last_nxt;
    end
  end

  assign cmd_o.op      = op;
  assign cmd_o.kind    = kind_r;
  assign cmd_o.use_cur = use_cur_r;
  assign cmd_o.act     = act_r;
  assign cmd_o.last    = last_r;

`ifndef SYNTHESIS
  a_accept_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (state_r == S_DISPATCH))
    else $error("accepted transaction did not reach dispatch");

  a_emit_then_leave: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT) |=> (state_r == S_IDLE || state_r == S_POLL_POP))
    else $error("emit state did not hand over");

  a_idle_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT && last_r) |=> !busy)
    else $error("final result did not release the block");
`endif

endmodule

FILE: rtl/delta_list_timer_queue_core.sv
// Channel   Direction  Handshake              Payload
// command   in         start high, busy low   in_command, in_timer_id, in_period, in_repeat_req
// result    out        out_valid for 1 cycle  out_kind, out_fired_or_addressed_id,
//                                             out_active, out_last
//
// A transaction runs one step at a time through the controller and the shared list datapath.
// Each result is registered and shows in the cycle after its emit step.
// Tick: only the result on an empty list, else a head decrement and then one pop per expiring
// entry. Stop: a walk that locates a running or ready slot, then its removal. Start: likewise,
// then the ordered insertion walk. Poll: just the result if none is ready, else per result
// a pop from the ready queue and, for a repeating one, a period load and the insertion walk.
// Reset is synchronous, active low; all slots come up idle. Results cannot be stalled.
module delta_list_timer_queue_core #(
  parameter int NUM_TIMERS  = 16,
  parameter int PERIOD_BITS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  in_command,
  input  logic [3:0]  in_timer_id,
  input  logic [31:0] in_period,
  input  logic        in_repeat_req,
  output logic        out_valid,
  output logic [1:0]  out_kind,
  output logic [3:0]  out_fired_or_addressed_id,
  output logic        out_active,
  output logic        out_last
);

  dltq_pkg::dp_cmd_t    dp_cmd;
  dltq_pkg::dp_status_t dp_status;

  dltq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .status_i (dp_status),
    .cmd_o    (dp_cmd)
  );

  dltq_dp #(
    .NUM_TIMERS  (NUM_TIMERS),
    .PERIOD_BITS (PERIOD_BITS)
  ) u_dp (
    .clk                       (clk),
    .rst_n                     (rst_n),
    .in_command                (in_command),
    .in_timer_id               (in_timer_id),
    .in_period                 (in_period),
    .in_repeat_req             (in_repeat_req),
    .cmd_i                     (dp_cmd),
    .status_o                  (dp_status),
    .out_valid                 (out_valid),
    .out_kind                  (out_kind),
    .out_fired_or_addressed_id (out_fired_or_addressed_id),
    .out_active                (out_active),
    .out_last                  (out_last)
  );

endmodule

FILE: test/tb_delta_list_timer_queue_core.sv
module tb_delta_list_timer_queue_core;

  typedef struct packed {
    logic [1:0] kind;
    logic [3:0] id;
    logic       act;
    logic       last;
  } timer_result_t;

  class timer_queue_scoreboard;
    logic [31:0]   period_of[16];
    logic [31:0]   delta_of[16];
    logic          reload[16];
    logic [1:0]    place[16];
    logic [3:0]    order[16];
    int            run_cnt;
    logic [3:0]    ready_q[16];
    int            ready_cnt;
    logic [31:0]   head_left;
    timer_result_t expected_results[$];
    int            mismatches;

    function void clear();
      for (int i = 0; i < 16; i++) begin
        reload[i] = 0;
        place[i] = dltq_pkg::PLACE_IDLE;
      end
      run_cnt = 0;
      ready_cnt = 0;
      head_left = 0;
      mismatches = 0;
      expected_results.delete();
    endfunction

    function void head_in();
      if (run_cnt > 0) delta_of[order[0]] = head_left;
    endfunction

    function void head_out();
      head_left = (run_cnt > 0) ? delta_of[order[0]] : 32'd0;
    endfunction

    function logic running(logic [3:0] id);
      return place[id] == dltq_pkg::PLACE_RUNNING;
    endfunction

    function void unlink(logic [3:0] id);
      int k;
      k = 0;
      while (k < run_cnt && order[k] != id) k++;
      if (k >= run_cnt) return;
      head_in();
      if (k + 1 < run_cnt) delta_of[order[k+1]] = delta_of[order[k+1]] + delta_of[id];
      for (int i = k; i + 1 < run_cnt; i++) order[i] = order[i+1];
      run_cnt--;
      place[id] = dltq_pkg::PLACE_IDLE;
      head_out();
    endfunction

    // Ties go behind: the walk stops only where the running sum exceeds the period.
    function void link_sorted(logic [3:0] id);
      longint unsigned sum;
      int pos;
      logic [31:0] d;
      sum = 0;
      pos = run_cnt;
      head_in();
      for (int i = 0; i < run_cnt; i++) begin
        sum += delta_of[order[i]];
        if (sum > period_of[id]) begin
          pos = i;
          break;
        end
      end
      if (pos < run_cnt) begin
        d = period_of[id] - 32'(sum - delta_of[order[pos]]);
        delta_of[order[pos]] = delta_of[order[pos]] - d;
      end else begin
        d = period_of[id] - 32'(sum);
      end
      delta_of[id] = d;
      for (int i = run_cnt; i > pos; i--) order[i] = order[i-1];
      order[pos] = id;
      run_cnt++;
      place[id] = dltq_pkg::PLACE_RUNNING;
      head_out();
    endfunction

    function void unready(logic [3:0] id);
      int k;
      k = 0;
      while (k < ready_cnt && ready_q[k] != id) k++;
      if (k >= ready_cnt) return;
      for (int i = k; i + 1 < ready_cnt; i++) ready_q[i] = ready_q[i+1];
      ready_cnt--;
      place[id] = dltq_pkg::PLACE_IDLE;
    endfunction

    function void take_out(logic [3:0] id);
      if (place[id] == dltq_pkg::PLACE_RUNNING) unlink(id);
      else if (place[id] == dltq_pkg::PLACE_READY) unready(id);
    endfunction

    function void add(logic [1:0] kind, logic [3:0] id, logic act);
      timer_result_t r;
      r.kind = kind;
      r.id = id;
      r.act = act;
      r.last = 0;
      expected_results.push_back(r);
    endfunction

    function void note_command(logic [2:0] cmd, logic [3:0] id, logic [31:0] p, logic rep);
      logic [3:0] t;
      int n;
      case (cmd)
        dltq_pkg::CMD_TICK: begin
          if (run_cnt > 0) begin
            head_left--;
            if (head_left == 0) begin
              delta_of[order[0]] = 0;
              while (run_cnt > 0 && delta_of[order[0]] == 0) begin
                t = order[0];
                unlink(t);
                if (ready_cnt < 16) begin
                  ready_q[ready_cnt++] = t;
                  place[t] = dltq_pkg::PLACE_READY;
                end
              end
            end
          end
          add(dltq_pkg::KIND_DONE, id, running(id));
        end
        dltq_pkg::CMD_START: begin
          if (p == 0) begin
            add(dltq_pkg::KIND_REJECT, id, running(id));
          end else begin
            take_out(id);
            period_of[id] = p;
            reload[id] = rep;
            link_sorted(id);
            add(dltq_pkg::KIND_DONE, id, 1'b1);
          end
        end
        dltq_pkg::CMD_STOP: begin
          take_out(id);
          add(dltq_pkg::KIND_DONE, id, 1'b0);
        end
        dltq_pkg::CMD_MODE: begin
          reload[id] = rep;
          add(dltq_pkg::KIND_DONE, id, running(id));
        end
        dltq_pkg::CMD_POLL: begin
          if (ready_cnt == 0) begin
            add(dltq_pkg::KIND_EMPTY, id, running(id));
          end else begin
            n = 0;
            while (ready_cnt > 0 && n < dltq_pkg::MAX_RESULTS) begin
              t = ready_q[0];
              unready(t);
              if (reload[t]) link_sorted(t);
              add(dltq_pkg::KIND_FIRED, t, running(t));
              n++;
            end
          end
        end
        default: add(dltq_pkg::KIND_REJECT, id, running(id));
      endcase
      expected_results[$].last = 1'b1;
    endfunction

    function void check_result(timer_result_t got);
      timer_result_t want;
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Unexpected result: kind %0d id %0d active %0d last %0d",
                   got.kind, got.id, got.act, got.last);
        return;
      end
      want = expected_results.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Mismatch: expected kind %0d id %0d active %0d last %0d, got %0d %0d %0d %0d",
                   want.kind, want.id, want.act, want.last,
                   got.kind, got.id, got.act, got.last);
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [2:0]  in_command;
  logic [3:0]  in_timer_id;
  logic [31:0] in_period;
  logic        in_repeat_req;
  logic        out_valid;
  logic [1:0]  out_kind;
  logic [3:0]  out_fired_or_addressed_id;
  logic        out_active;
  logic        out_last;

  timer_queue_scoreboard timers = new();
  bit no_gaps;

  delta_list_timer_queue_core i_dut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_command(in_command),
    .in_timer_id(in_timer_id),
    .in_period(in_period),
    .in_repeat_req(in_repeat_req),
    .out_valid(out_valid),
    .out_kind(out_kind),
    .out_fired_or_addressed_id(out_fired_or_addressed_id),
    .out_active(out_active),
    .out_last(out_last)
  );

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid)
      timers.check_result({out_kind, out_fired_or_addressed_id, out_active, out_last});
  end

  // Called at a rising edge; returns at the edge that accepts the transaction.
  task automatic send_command(logic [2:0] cmd, logic [3:0] id, logic [31:0] p, logic rep);
    int gap;
    gap = (!no_gaps && $urandom_range(99) < 34) ? $urandom_range(1, 5) : 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_command <= cmd;
    in_timer_id <= id;
    in_period <= p;
    in_repeat_req <= rep;
    do @(posedge clk); while (busy);
    timers.note_command(cmd, id, p, rep);
  endtask

  task automatic random_command();
    int r;
    logic [31:0] p;
    r = $urandom_range(99);
    p = ($urandom_range(9) == 0) ? $urandom : $urandom_range(8, 1);
    if ($urandom_range(24) == 0) p = 0;
    if (r < 35)
      send_command(dltq_pkg::CMD_TICK, 4'($urandom), $urandom, 1'($urandom));
    else if (r < 60)
      send_command(dltq_pkg::CMD_START, 4'($urandom), p, 1'($urandom));
    else if (r < 70)
      send_command(dltq_pkg::CMD_STOP, 4'($urandom), $urandom, 1'($urandom));
    else if (r < 78)
      send_command(dltq_pkg::CMD_MODE, 4'($urandom), $urandom, 1'($urandom));
    else if (r < 95)
      send_command(dltq_pkg::CMD_POLL, 4'($urandom), $urandom, 1'($urandom));
    else
      send_command(3'($urandom_range(7, 5)), 4'($urandom), $urandom, 1'($urandom));
  endtask

  initial begin
    #4000000;
    $display("Some tests failed");
    $finish;
  end

  initial begin
    int waited;
    timers.clear();
    rst_n = 0;
    start = 0;
    in_command = dltq_pkg::CMD_TICK;
    in_timer_id = 0;
    in_period = 0;
    in_repeat_req = 0;
    no_gaps = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_command(dltq_pkg::CMD_TICK, 4'd0, 32'd0, 1'b0);
    send_command(dltq_pkg::CMD_POLL, 4'd15, 32'hFFFFFFFF, 1'b1);
    send_command(dltq_pkg::CMD_START, 4'd5, 32'd0, 1'b1);
    send_command(dltq_pkg::CMD_STOP, 4'd7, 32'd0, 1'b0);
    send_command(dltq_pkg::CMD_MODE, 4'd9, 32'd0, 1'b1);
    for (int c = 5; c <= 7; c++) send_command(3'(c), 4'd2, 32'd3, 1'b0);
    send_command(dltq_pkg::CMD_START, 4'd3, 32'hFFFFFFFF, 1'b1);
    send_command(dltq_pkg::CMD_START, 4'd0, 32'd1, 1'b0);
    send_command(dltq_pkg::CMD_START, 4'd1, 32'd2, 1'b1);
    send_command(dltq_pkg::CMD_START, 4'd2, 32'd2, 1'b0);
    send_command(dltq_pkg::CMD_START, 4'd4, 32'd2, 1'b1);
    send_command(dltq_pkg::CMD_TICK, 4'd0, 32'd0, 1'b0);
    send_command(dltq_pkg::CMD_STOP, 4'd0, 32'd0, 1'b0);
    send_command(dltq_pkg::CMD_TICK, 4'd1, 32'd0, 1'b0);
    send_command(dltq_pkg::CMD_MODE, 4'd2, 32'd0, 1'b1);
    send_command(dltq_pkg::CMD_POLL, 4'd0, 32'd0, 1'b0);
    send_command(dltq_pkg::CMD_START, 4'd1, 32'd5, 1'b0);
    send_command(dltq_pkg::CMD_STOP, 4'd3, 32'd0, 1'b0);
    send_command(dltq_pkg::CMD_TICK, 4'd0, 32'd0, 1'b0);
    send_command(dltq_pkg::CMD_POLL, 4'd6, 32'd0, 1'b0);

    for (int i = 0; i < 120; i++) begin
      no_gaps = (i >= 40 && i < 80);
      random_command();
    end
    start <= 1'b0;

    waited = 0;
    while (timers.expected_results.size() != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    repeat (100) @(posedge clk);
    if (timers.mismatches == 0 && timers.expected_results.size() == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end
endmodule

FILE: delta_list_timer_queue_core.f
rtl/dltq_pkg.sv
rtl/dltq_ram.sv
rtl/dltq_dp.sv
rtl/dltq_ctrl.sv
rtl/delta_list_timer_queue_core.sv
test/tb_delta_list_timer_queue_core.sv
